@@ rtl/core/ptpp_pkg.sv @@
package ptpp_pkg;

    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS_DEF = 10;
    localparam int DIST_W = 49;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int MUL_W = DIFF_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SUM_W = PROD_W + 1;
    localparam int SQ_W = 2 * COORD_BITS + 1;
    localparam int MAG_W = 2 * DIFF_W;
    localparam int HALF_W = DIFF_W;
    localparam int NUM_W = 2 * MAG_W;
    localparam int CNT_W = $clog2(MAG_W);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] person_x;
        logic signed [COORD_BITS-1:0] person_y;
        logic                         first_vertex;
        logic                         last_vertex;
    } vertex_t;

    typedef struct packed {
        logic              on_path;
        logic              found;
        logic [DIST_W-1:0] min_dist_sq;
    } result_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIFF,
        S_DX,
        S_DY,
        S_DD,
        S_SY,
        S_SS,
        S_C2,
        S_CR,
        S_Q1,
        S_Q2,
        S_Q3,
        S_Q4,
        S_DIV,
        S_LIN,
        S_T2,
        S_T,
        S_E2,
        S_EE,
        S_UPD,
        S_FIN
    } state_t;

endpackage

@@ rtl/core/point_to_polyline_proximity.sv @@
// channel   dir  handshake               payload
// in        in   in_valid / in_ready     in_data (vertex_t)
// out       out  out_valid / out_ready   out_data (result_t)
// cfg       in   cfg_wr_en               cfg_wr_data (threshold_sq)
//
// a vertex with no segment goes straight to the final step; a segment ends early
// on a query at the start, a zero length segment, or a line distance that cannot
// win; one shared 26x26 multiplier, then a 50-step restoring divider for the
// squared line distance, one quotient bit a cycle
// in_ready is high only while the sequencer is idle; a result waits in the output
// register, the final step of the next path end holds until that register is free
// rst_n clears the path state and loads the threshold reset value
module point_to_polyline_proximity
    import ptpp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  vertex_t           in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output result_t           out_data,
    input  logic              cfg_wr_en,
    input  logic [DIST_W-1:0] cfg_wr_data
);

    localparam longint unsigned EPS_RAW =
        ((64'd1 << (2 * FRAC_BITS)) + 64'd9999999999) / 64'd10000000000;
    localparam logic signed [SUM_W-1:0] EPS_SQ = SUM_W'(EPS_RAW);

    state_t state_reg, state_next;

    logic [DIST_W-1:0] threshold_reg;

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_y_reg, cur_x_next, cur_y_next;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg, prev_x_next, prev_y_next;
    logic signed [COORD_BITS-1:0] query_x_reg, query_y_reg, query_x_next, query_y_next;
    logic [SQ_W-1:0] best_reg, best_next;
    logic best_valid_reg, best_valid_next;
    logic hit_zero_reg, hit_zero_next;
    logic have_prev_reg, have_prev_next;
    logic last_reg, last_next;

    logic signed [DIFF_W-1:0] dx_reg, dy_reg, sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [DIFF_W-1:0] dx_next, dy_next, sx_next, sy_next, ex_next, ey_next;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [SUM_W-1:0]  acc_reg, acc_next;
    logic signed [SUM_W-1:0]  sum_add, sum_sub;

    logic [SQ_W-1:0]  dd_reg, dd_next, ss_reg, ss_next, cand_reg, cand_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [SQ_W-1:0]  rem_reg, rem_next;
    logic [MAG_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [SQ_W:0]      trial;
    logic [SQ_W-1:0]    lin;
    logic signed [SUM_W-1:0] ss_ext;
    logic [HALF_W-1:0]  mag_lo, mag_hi;
    logic [NUM_W-1:0]   prod_u;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    logic in_xfer, seg_go;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign sum_add = acc_reg + SUM_W'(prod_reg);
    assign sum_sub = acc_reg - SUM_W'(prod_reg);
    assign prod_u  = NUM_W'($unsigned(prod_reg));
    assign mag_lo  = mag_reg[HALF_W-1:0];
    assign mag_hi  = mag_reg[MAG_W-1:HALF_W];
    assign trial   = {rem_reg, num_reg[MAG_W-1]};
    assign lin     = quo_reg[SQ_W-1:0];
    assign ss_ext  = $signed(SUM_W'(ss_reg));
    assign seg_go  = !in_data.first_vertex && have_prev_reg && !hit_zero_reg;

    // shared multiplier
    assign prod_next = mul_a * mul_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = seg_go ? S_DIFF : S_FIN;
                end
            end
            S_DIFF: state_next = S_DX;
            S_DX:   state_next = S_DY;
            S_DY:   state_next = S_DD;
            S_DD:   state_next = (sum_add < EPS_SQ) ? S_FIN : S_SY;
            S_SY:   state_next = S_SS;
            S_SS:   state_next = (sum_add < EPS_SQ) ? S_FIN : S_C2;
            S_C2:   state_next = S_CR;
            S_CR:   state_next = S_Q1;
            S_Q1:   state_next = S_Q2;
            S_Q2:   state_next = S_Q3;
            S_Q3:   state_next = S_Q4;
            S_Q4:   state_next = S_DIV;
            S_DIV:  state_next = (cnt_reg == '0) ? S_LIN : S_DIV;
            S_LIN:  state_next = (best_valid_reg && lin >= best_reg) ? S_FIN : S_T2;
            S_T2:   state_next = S_T;
            S_T:
            begin
                if (sum_add < 0)
                begin
                    state_next = S_UPD;
                end
                else if (sum_add > ss_ext)
                begin
                    state_next = S_E2;
                end
                else
                begin
                    state_next = S_UPD;
                end
            end
            S_E2:   state_next = S_EE;
            S_EE:   state_next = (sum_add < EPS_SQ) ? S_FIN : S_UPD;
            S_UPD:  state_next = S_FIN;
            S_FIN:
            begin
                if (!last_reg || !out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        query_x_next    = query_x_reg;
        query_y_next    = query_y_reg;
        best_next       = best_reg;
        best_valid_next = best_valid_reg;
        hit_zero_next   = hit_zero_reg;
        have_prev_next  = have_prev_reg;
        last_next       = last_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        ex_next         = ex_reg;
        ey_next         = ey_reg;
        acc_next        = acc_reg;
        dd_next         = dd_reg;
        ss_next         = ss_reg;
        cand_next       = cand_reg;
        mag_next        = mag_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        mul_a           = MUL_W'(dx_reg);
        mul_b           = MUL_W'(dx_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cur_x_next = in_data.point_x;
                    cur_y_next = in_data.point_y;
                    last_next  = in_data.last_vertex;
                    if (in_data.first_vertex)
                    begin
                        query_x_next    = in_data.person_x;
                        query_y_next    = in_data.person_y;
                        best_next       = '0;
                        best_valid_next = 1'b0;
                        hit_zero_next   = 1'b0;
                        have_prev_next  = 1'b0;
                    end
                end
            end
            S_DIFF:
            begin
                dx_next = DIFF_W'(query_x_reg) - DIFF_W'(prev_x_reg);
                dy_next = DIFF_W'(query_y_reg) - DIFF_W'(prev_y_reg);
                sx_next = DIFF_W'(cur_x_reg) - DIFF_W'(prev_x_reg);
                sy_next = DIFF_W'(cur_y_reg) - DIFF_W'(prev_y_reg);
                ex_next = DIFF_W'(query_x_reg) - DIFF_W'(cur_x_reg);
                ey_next = DIFF_W'(query_y_reg) - DIFF_W'(cur_y_reg);
            end
            S_DX:
            begin
                mul_a = MUL_W'(dx_reg);
                mul_b = MUL_W'(dx_reg);
            end
            S_DY:
            begin
                mul_a    = MUL_W'(dy_reg);
                mul_b    = MUL_W'(dy_reg);
                acc_next = SUM_W'(prod_reg);
            end
            S_DD:
            begin
                mul_a   = MUL_W'(sx_reg);
                mul_b   = MUL_W'(sx_reg);
                dd_next = sum_add[SQ_W-1:0];
                // query sits on the segment start
                if (sum_add < EPS_SQ)
                begin
                    best_next       = '0;
                    best_valid_next = 1'b1;
                    hit_zero_next   = 1'b1;
                end
            end
            S_SY:
            begin
                mul_a    = MUL_W'(sy_reg);
                mul_b    = MUL_W'(sy_reg);
                acc_next = SUM_W'(prod_reg);
            end
            S_SS:
            begin
                mul_a   = MUL_W'(sx_reg);
                mul_b   = MUL_W'(dy_reg);
                ss_next = sum_add[SQ_W-1:0];
            end
            S_C2:
            begin
                mul_a    = MUL_W'(sy_reg);
                mul_b    = MUL_W'(dx_reg);
                acc_next = SUM_W'(prod_reg);
            end
            S_CR:
            begin
                mag_next = sum_sub[SUM_W-1] ? MAG_W'(-sum_sub) : MAG_W'(sum_sub);
            end
            // square of |cross| from 25-bit halves
            S_Q1:
            begin
                mul_a = MUL_W'($signed({1'b0, mag_lo}));
                mul_b = MUL_W'($signed({1'b0, mag_lo}));
            end
            S_Q2:
            begin
                mul_a    = MUL_W'($signed({1'b0, mag_lo}));
                mul_b    = MUL_W'($signed({1'b0, mag_hi}));
                num_next = prod_u;
            end
            S_Q3:
            begin
                mul_a    = MUL_W'($signed({1'b0, mag_hi}));
                mul_b    = MUL_W'($signed({1'b0, mag_hi}));
                num_next = num_reg + (prod_u << (HALF_W + 1));
            end
            S_Q4:
            begin
                num_next = num_reg + (prod_u << (2 * HALF_W));
                // quotient stays below 2^49, so the upper half is already below ss
                rem_next = num_next[MAG_W+SQ_W-1:MAG_W];
                quo_next = '0;
                cnt_next = CNT_W'(MAG_W - 1);
            end
            S_DIV:
            begin
                num_next = num_reg << 1;
                if (trial >= {1'b0, ss_reg})
                begin
                    rem_next = SQ_W'(trial - {1'b0, ss_reg});
                    quo_next = {quo_reg[MAG_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[SQ_W-1:0];
                    quo_next = {quo_reg[MAG_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
            end
            S_LIN:
            begin
                mul_a = MUL_W'(sx_reg);
                mul_b = MUL_W'(dx_reg);
            end
            S_T2:
            begin
                mul_a    = MUL_W'(sy_reg);
                mul_b    = MUL_W'(dy_reg);
                acc_next = SUM_W'(prod_reg);
            end
            S_T:
            begin
                mul_a = MUL_W'(ex_reg);
                mul_b = MUL_W'(ex_reg);
                // projection before the start, past the end, or inside
                if (sum_add < 0)
                begin
                    cand_next = dd_reg;
                end
                else
                begin
                    cand_next = lin;
                end
            end
            S_E2:
            begin
                mul_a    = MUL_W'(ey_reg);
                mul_b    = MUL_W'(ey_reg);
                acc_next = SUM_W'(prod_reg);
            end
            S_EE:
            begin
                cand_next = sum_add[SQ_W-1:0];
                if (sum_add < EPS_SQ)
                begin
                    best_next       = '0;
                    best_valid_next = 1'b1;
                    hit_zero_next   = 1'b1;
                end
            end
            S_UPD:
            begin
                if (!best_valid_reg || cand_reg < best_reg)
                begin
                    best_next       = cand_reg;
                    best_valid_next = 1'b1;
                end
            end
            S_FIN:
            begin
                if (!last_reg)
                begin
                    prev_x_next    = cur_x_reg;
                    prev_y_next    = cur_y_reg;
                    have_prev_next = 1'b1;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    prev_x_next         = cur_x_reg;
                    prev_y_next         = cur_y_reg;
                    out_next.on_path    = best_valid_reg &&
                                          (DIST_W'(best_reg) <= threshold_reg);
                    out_next.found      = best_valid_reg;
                    out_next.min_dist_sq = best_valid_reg ? DIST_W'(best_reg) : '0;
                    out_valid_next      = 1'b1;
                    have_prev_next      = 1'b0;
                    best_valid_next     = 1'b0;
                    hit_zero_next       = 1'b0;
                    best_next           = '0;
                end
            end
            default:
            begin
                best_next = best_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            threshold_reg  <= DIST_W'(892967);
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            query_x_reg    <= '0;
            query_y_reg    <= '0;
            best_reg       <= '0;
            best_valid_reg <= 1'b0;
            hit_zero_reg   <= 1'b0;
            have_prev_reg  <= 1'b0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_wr_en)
            begin
                threshold_reg <= cfg_wr_data;
            end
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            query_x_reg    <= query_x_next;
            query_y_reg    <= query_y_next;
            best_reg       <= best_next;
            best_valid_reg <= best_valid_next;
            hit_zero_reg   <= hit_zero_next;
            have_prev_reg  <= have_prev_next;
            last_reg       <= last_next;
            out_valid_reg  <= out_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        ex_reg    <= ex_next;
        ey_reg    <= ey_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        dd_reg    <= dd_next;
        ss_reg    <= ss_next;
        cand_reg  <= cand_next;
        mag_reg   <= mag_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        out_reg   <= out_next;
    end

endmodule
